FILE: src/matrix_multiply_engine_core_defines.svh
// Assertion macros for the matrix multiply engine.
// Included by the top level; no other dependencies.
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mme_pkg.sv
// Shared types, codes and constants of the matrix multiply engine.
// No dependencies; used by every module of the block but mme_ram.
`timescale 1ns / 1ps

package mme_pkg;

  localparam int MAX_ROWS_DEF  = 8;
  localparam int MAX_INNER_DEF = 8;
  localparam int MAX_COLS_DEF  = 8;

  localparam int ELEM_W   = 16;
  localparam int IDX_W    = 3;
  localparam int DIM_W    = 4;
  localparam int ACC_W    = 40;
  localparam int FRAC_W   = 12;
  localparam int PROD_W   = 2 * ELEM_W;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input mode codes.
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_INNER = 2'd1;
  localparam logic [1:0] CFG_COLS  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic [ELEM_W-1:0]       value;
  } cmd_t;

  // Dimensions after clamping to the legal range.
  typedef struct packed {
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
  } dims_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  typedef struct packed {
    logic running;
    logic pipe_busy;
  } back_stat_t;

endpackage

FILE: src/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mme_front.sv
// Front end: request acceptance, classification and the configuration registers.
// Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_front #(
  parameter int MAX_ROWS  = mme_pkg::MAX_ROWS_DEF,
  parameter int MAX_INNER = mme_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = mme_pkg::MAX_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic [mme_pkg::IDX_W-1:0]    in_row,
  input  logic [mme_pkg::IDX_W-1:0]    in_col,
  input  logic signed [mme_pkg::ELEM_W-1:0] in_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]    cfg_data,
  input  mme_pkg::queue_stat_t         q_stat,
  output logic                         push,
  output mme_pkg::cmd_t                cmd,
  output mme_pkg::dims_t               dims
);

  logic [mme_pkg::DIM_W-1:0] rows_r;
  logic [mme_pkg::DIM_W-1:0] inner_r;
  logic [mme_pkg::DIM_W-1:0] cols_r;
  logic                      keep;

  function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(
    input logic [mme_pkg::DIM_W-1:0] v,
    input int                        max_v
  );
    logic [mme_pkg::DIM_W-1:0] res;
    if (v == '0) begin
      res = mme_pkg::DIM_W'(1);
    end else if (32'(v) > max_v) begin
      res = mme_pkg::DIM_W'(max_v);
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= mme_pkg::DIM_RESET;
      inner_r <= mme_pkg::DIM_RESET;
      cols_r  <= mme_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mme_pkg::CFG_ROWS:  rows_r  <= cfg_data;
        mme_pkg::CFG_INNER: inner_r <= cfg_data;
        mme_pkg::CFG_COLS:  cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dims.nr = clamp_dim(rows_r, MAX_ROWS);
  assign dims.nk = clamp_dim(inner_r, MAX_INNER);
  assign dims.nc = clamp_dim(cols_r, MAX_COLS);

  assign busy = q_stat.full;

  // Loads that fall outside their store and the unused mode are dropped here,
  // so they never reach the queue.
  always_comb begin
    cmd.row   = in_row;
    cmd.col   = in_col;
    cmd.value = in_value;
    cmd.kind  = mme_pkg::CMD_COMPUTE;
    keep      = 1'b0;
    case (in_mode)
      mme_pkg::MODE_LOAD_A: begin
        cmd.kind = mme_pkg::CMD_LOAD_A;
        keep     = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_INNER);
      end
      mme_pkg::MODE_LOAD_B: begin
        cmd.kind = mme_pkg::CMD_LOAD_B;
        keep     = (32'(in_row) < MAX_INNER) && (32'(in_col) < MAX_COLS);
      end
      mme_pkg::MODE_COMPUTE: begin
        cmd.kind = mme_pkg::CMD_COMPUTE;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = start && !busy && keep;

endmodule

FILE: src/mme_queue.sv
// Short command queue between the front and back ends.
// Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mme_pkg::cmd_t        cmd_in,
  input  logic                 pop,
  output mme_pkg::cmd_t        cmd_out,
  output mme_pkg::queue_stat_t stat
);

  localparam int DEPTH = mme_pkg::QUEUE_DEPTH;
  localparam int PW    = mme_pkg::QPTR_W;
  localparam int CW    = mme_pkg::QCNT_W;

  mme_pkg::cmd_t  slots_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push;
  logic           do_pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PW'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = PW'(p + 1'b1);
    end
    return n;
  endfunction

  assign do_push = push && (count_r != CW'(DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
    if (do_push) begin
      slots_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign cmd_out    = slots_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

FILE: src/mme_back.sv
// Back end: executes loads into the element stores and sequences the
// multiply-accumulate pipeline for a compute request.
// Depends on mme_pkg and mme_ram.
`timescale 1ns / 1ps

module mme_back #(
  parameter int MAX_ROWS  = mme_pkg::MAX_ROWS_DEF,
  parameter int MAX_INNER = mme_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = mme_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mme_pkg::queue_stat_t              q_stat,
  input  mme_pkg::cmd_t                     cmd,
  output logic                              pop,
  input  mme_pkg::dims_t                    dims,
  output logic                              out_valid,
  output logic [mme_pkg::IDX_W-1:0]         out_row,
  output logic [mme_pkg::IDX_W-1:0]         out_col,
  output logic signed [mme_pkg::ELEM_W-1:0] out_value,
  output logic                              out_last,
  output mme_pkg::back_stat_t               stat
);

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int AAW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int BAW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int EW      = mme_pkg::ELEM_W;
  localparam int XW      = mme_pkg::IDX_W;
  localparam int DW      = mme_pkg::DIM_W;
  localparam int AW      = mme_pkg::ACC_W;
  localparam int PW      = mme_pkg::PROD_W;
  localparam int FW      = mme_pkg::FRAC_W;
  localparam int QW      = AW - FW + 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t          state_r, state_nxt;
  mme_pkg::dims_t  dims_r, dims_nxt;
  logic [DW-1:0]   i_r, i_nxt;
  logic [DW-1:0]   j_r, j_nxt;
  logic [DW-1:0]   k_r, k_nxt;
  logic            i_last, j_last, k_last;
  logic            issue;

  logic            a_we, b_we;
  logic [AAW-1:0]  a_waddr, a_raddr;
  logic [BAW-1:0]  b_waddr, b_raddr;
  logic [EW-1:0]   a_rdata, b_rdata;

  // Stage 1: store read data arriving.
  logic            s1_v_r, s1_first_r, s1_lastk_r, s1_lastel_r;
  logic [XW-1:0]   s1_row_r, s1_col_r;
  // Stage 2: product registered.
  logic            s2_v_r, s2_first_r, s2_lastk_r, s2_lastel_r;
  logic [XW-1:0]   s2_row_r, s2_col_r;
  logic signed [PW-1:0] s2_prod_r;
  // Stage 3: finished dot product waiting to be rounded.
  logic            s3_v_r, s3_lastel_r;
  logic [XW-1:0]   s3_row_r, s3_col_r;
  logic signed [AW-1:0] fin_r;

  logic signed [AW-1:0] acc_r, acc_nxt;

  logic            out_valid_r, out_last_r;
  logic [XW-1:0]   out_row_r, out_col_r;
  logic [EW-1:0]   out_value_r;

  // Round half up to Q4.12, then saturate to the element range.
  function automatic logic [EW-1:0] round_sat(input logic signed [AW-1:0] a);
    logic signed [AW:0]   t;
    logic signed [QW-1:0] q;
    logic [EW-1:0]        res;
    t = {a[AW-1], a} + (AW + 1)'(1 << (FW - 1));
    q = t[AW:FW];
    if (q > QW'(32767)) begin
      res = {1'b0, {(EW - 1){1'b1}}};
    end else if (q < -QW'(32768)) begin
      res = {1'b1, {(EW - 1){1'b0}}};
    end else begin
      res = q[EW-1:0];
    end
    return res;
  endfunction

  assign pop = (state_r == ST_IDLE) && !q_stat.empty;

  assign a_we    = pop && (cmd.kind == mme_pkg::CMD_LOAD_A);
  assign b_we    = pop && (cmd.kind == mme_pkg::CMD_LOAD_B);
  assign a_waddr = AAW'(32'(cmd.row) * MAX_INNER + 32'(cmd.col));
  assign b_waddr = BAW'(32'(cmd.row) * MAX_COLS + 32'(cmd.col));
  assign a_raddr = AAW'(32'(i_r) * MAX_INNER + 32'(k_r));
  assign b_raddr = BAW'(32'(k_r) * MAX_COLS + 32'(j_r));

  mme_ram #(.WIDTH(EW), .DEPTH(A_DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (cmd.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mme_ram #(.WIDTH(EW), .DEPTH(B_DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (cmd.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign i_last = (i_r == DW'(dims_r.nr - 1'b1));
  assign j_last = (j_r == DW'(dims_r.nc - 1'b1));
  assign k_last = (k_r == DW'(dims_r.nk - 1'b1));
  assign issue  = (state_r == ST_RUN);

  always_comb begin
    state_nxt = state_r;
    dims_nxt  = dims_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && (cmd.kind == mme_pkg::CMD_COMPUTE)) begin
          state_nxt = ST_RUN;
          dims_nxt  = dims;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        // Inner index fastest, then column, then row.
        if (!k_last) begin
          k_nxt = DW'(k_r + 1'b1);
        end else begin
          k_nxt = '0;
          if (!j_last) begin
            j_nxt = DW'(j_r + 1'b1);
          end else begin
            j_nxt = '0;
            if (!i_last) begin
              i_nxt = DW'(i_r + 1'b1);
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign acc_nxt = (s2_first_r ? '0 : acc_r) + AW'(s2_prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dims_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      dims_r      <= dims_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r && s2_lastk_r;
      out_valid_r <= s3_v_r;
      if (s2_v_r) begin
        acc_r <= acc_nxt;
      end
    end
    s1_first_r  <= (k_r == '0);
    s1_lastk_r  <= k_last;
    s1_lastel_r <= i_last && j_last;
    s1_row_r    <= i_r[XW-1:0];
    s1_col_r    <= j_r[XW-1:0];
    s2_first_r  <= s1_first_r;
    s2_lastk_r  <= s1_lastk_r;
    s2_lastel_r <= s1_lastel_r;
    s2_row_r    <= s1_row_r;
    s2_col_r    <= s1_col_r;
    s2_prod_r   <= $signed(a_rdata) * $signed(b_rdata);
    if (s2_v_r && s2_lastk_r) begin
      fin_r       <= acc_nxt;
      s3_lastel_r <= s2_lastel_r;
      s3_row_r    <= s2_row_r;
      s3_col_r    <= s2_col_r;
    end
    out_value_r <= round_sat(fin_r);
    out_last_r  <= s3_lastel_r;
    out_row_r   <= s3_row_r;
    out_col_r   <= s3_col_r;
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r && out_valid_r;

  assign stat.running   = (state_r == ST_RUN);
  assign stat.pipe_busy = (state_r == ST_RUN) || s1_v_r || s2_v_r || s3_v_r;

endmodule

FILE: src/matrix_multiply_engine_core.sv
// Top level of the matrix multiply engine: front end, command queue, back end.
// Depends on mme_pkg, mme_front, mme_queue, mme_back and the defines header.
//
//   Channel  Handshake              Payload
//   input    start / busy           in_mode, in_row, in_col, in_value
//   result   out_valid (strobe)     out_row, out_col, out_value, out_last
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load request is written into its store when popped, so loads stream at one per
// cycle while no compute runs. A compute request holds the back end for rows x inner
// x cols products, one multiply-accumulate per cycle, bounded by the single read port
// of each store; each result then passes the s1, s2, s3 and output registers.
// busy rises when the two-entry queue is full, i.e. behind a running compute.
// Reset is synchronous; the element stores are not cleared and need loading.
// Results cannot be stalled; each is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "matrix_multiply_engine_core_defines.svh"

module matrix_multiply_engine_core #(
  parameter int MAX_ROWS  = mme_pkg::MAX_ROWS_DEF,
  parameter int MAX_INNER = mme_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = mme_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic [mme_pkg::IDX_W-1:0]         in_row,
  input  logic [mme_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mme_pkg::ELEM_W-1:0] in_value,
  output logic                              out_valid,
  output logic [mme_pkg::IDX_W-1:0]         out_row,
  output logic [mme_pkg::IDX_W-1:0]         out_col,
  output logic signed [mme_pkg::ELEM_W-1:0] out_value,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]         cfg_data
);

  mme_pkg::queue_stat_t q_stat;
  mme_pkg::back_stat_t  b_stat;
  mme_pkg::cmd_t        front_cmd;
  mme_pkg::cmd_t        head_cmd;
  mme_pkg::dims_t       dims;
  logic                 push;
  logic                 pop;

  mme_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_mode   (in_mode),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (front_cmd),
    .dims      (dims)
  );

  mme_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (front_cmd),
    .pop     (pop),
    .cmd_out (head_cmd),
    .stat    (q_stat)
  );

  mme_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .cmd       (head_cmd),
    .pop       (pop),
    .dims      (dims),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last),
    .stat      (b_stat)
  );

  // A final result is never followed at once by another: the next compute
  // needs at least a pop and an issue cycle.
  `MME_ASSERT_NEXT(a_last_gap, clk, rst_n, out_valid && out_last, !out_valid, "result straight after last")
  // After any result other than the last, more work must still be in flight.
  `MME_ASSERT_IMP(a_more_pending, clk, rst_n, out_valid && !out_last, b_stat.pipe_busy, "matrix cut short")
  // The queue never holds more than its depth.
  `MME_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, q_stat.count <= mme_pkg::QCNT_W'(mme_pkg::QUEUE_DEPTH), "queue overrun")

endmodule
